// ===== hw/rtl/bitmap_run_allocator_macros.svh =====
// Assertion macros for the bitmap run allocator.
// Expects clk and arst_n in the scope of each use.
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BRA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bra_pkg.sv =====
// Shared types, constants and helpers of the bitmap run allocator.
// No dependencies; imported by every module of the block.
package bra_pkg;

	localparam int POOL_WORDS = 16;
	localparam int WORD_BITS  = 32;
	localparam int IDX_W      = $clog2(POOL_WORDS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int POS_W      = $clog2(WORD_BITS);
	localparam int LEN_W      = 6;
	localparam int ENTRY_W    = 9;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [CNT_W-1:0] WORDS_RESET = CNT_W'(POOL_WORDS);

	// register index taken from paddr[ADDR_W-1:2]
	localparam logic [ADDR_W-3:0] REG_WORDS_IN_USE = '0;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                opcode;
		logic [LEN_W-1:0]   run_length;
		logic [ENTRY_W-1:0] start_offset;
	} req_t;

	typedef struct packed {
		logic               success;
		logic [ENTRY_W-1:0] granted_offset;
	} rsp_t;

	typedef struct packed {
		logic                 rd_en;
		logic [IDX_W-1:0]     rd_addr;
		logic                 wr_en;
		logic [IDX_W-1:0]     wr_addr;
		logic [WORD_BITS-1:0] wr_data;
	} mem_req_t;

	function automatic logic [WORD_BITS-1:0] run_mask(input logic [LEN_W-1:0] n);
		logic [WORD_BITS-1:0] m;
		if (n >= LEN_W'(WORD_BITS)) begin
			m = '1;
		end else begin
			m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/bra_bitmap_mem.sv =====
// Bitmap word store: one write port, one registered read port.
// Per-word valid bits make unwritten words read as free. Uses bra_pkg.
module bra_bitmap_mem
	import bra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  mem_req_t             mreq,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0]  mem_q [POOL_WORDS];
	logic [POOL_WORDS-1:0] valid_q;
	logic [WORD_BITS-1:0]  rd_data_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem_q[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rd_data_q <= mem_q[mreq.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (mreq.rd_en) begin
				rd_valid_q <= valid_q[mreq.rd_addr];
			end
			if (mreq.wr_en) begin
				valid_q[mreq.wr_addr] <= 1'b1;
			end
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/bra_fit_search.sv =====
// First-fit window search over a pair of adjacent bitmap words.
// Returns the lowest bit position where the run mask fits free. Uses bra_pkg.
module bra_fit_search
	import bra_pkg::*;
(
	input  logic [WORD_BITS-1:0] lo_word,
	input  logic [WORD_BITS-1:0] hi_word,
	input  logic [WORD_BITS-1:0] mask,
	output logic                 found,
	output logic [POS_W-1:0]     pos
);

	logic [WORD_BITS-1:0] fits;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			fits[j] = (({hi_word, lo_word} & ({{WORD_BITS{1'b0}}, mask} << j))
				== '0);
		end
	end

	always_comb begin
		pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (fits[j]) begin
				pos = POS_W'(j);
			end
		end
	end

	assign found = |fits;

endmodule

// ===== hw/rtl/bitmap_run_allocator.sv =====
// First-fit run allocator over a bitmap of up to 16 words of 32 entries, all
// free after reset. One request is in work at a time. An allocate reads one
// bitmap word per cycle from the single read port and tests every start
// position of a word pair at once; when it finds a fit it ends in one or two
// writes through the single write port. A free reads and writes back one or
// two words; a rejected request or a free of zero entries does neither.
// The result waits in an output register, so the next request is taken while
// an earlier result is still stalled; the last cycle of a request holds while
// that earlier result still waits.
module bitmap_run_allocator
	import bra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SCAN = 7'b0000010,
		ST_FRD0 = 7'b0000100,
		ST_FRD1 = 7'b0001000,
		ST_WR0  = 7'b0010000,
		ST_WR1  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     words_q;
	logic [CNT_W-1:0]     w_cfg;
	logic [CNT_W-1:0]     w_q;
	op_t                  op_q;
	logic [LEN_W-1:0]     n_q;
	logic [CNT_W-1:0]     idx_q;
	logic [IDX_W-1:0]     i_q;
	logic [POS_W-1:0]     j_q;
	logic                 span_q;
	logic [WORD_BITS-1:0] a_q, b_q;
	rsp_t                 res_q, res_d;
	logic                 res_load;
	logic                 out_valid_q;
	rsp_t                 out_q;

	logic                 accept;
	logic                 fin_load;
	logic                 cfg_wr;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] b_word;
	logic                 fit_found;
	logic [POS_W-1:0]     fit_pos;
	logic                 alloc_ok;
	logic                 free_ok;
	logic                 req_span;
	logic [CNT_W-1:0]     idx_inc;
	logic [CNT_W-1:0]     idx_dec;
	logic [CNT_W-1:0]     i_inc;
	logic [2*WORD_BITS-1:0] run_bits;
	mem_req_t             mreq;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= WORDS_RESET;
		end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_WORDS_IN_USE) begin
			words_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_WORDS_IN_USE) begin
			prdata[CNT_W-1:0] = words_q;
		end
	end

	// saturate pool size into 1 .. POOL_WORDS
	always_comb begin
		priority if (words_q == '0) begin
			w_cfg = CNT_W'(1);
		end else if (words_q > CNT_W'(POOL_WORDS)) begin
			w_cfg = CNT_W'(POOL_WORDS);
		end else begin
			w_cfg = words_q;
		end
	end

	assign accept    = req_valid & ~req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign mask      = run_mask(n_q);
	assign idx_inc   = idx_q + CNT_W'(1);
	assign idx_dec   = idx_q - CNT_W'(1);
	assign i_inc     = CNT_W'(i_q) + CNT_W'(1);
	assign b_word    = (idx_q < w_q) ? rdata : '1;
	assign run_bits  = {{WORD_BITS{1'b0}}, mask} << j_q;
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || !rsp_stall);

	assign alloc_ok = (req.run_length != '0) && (req.run_length <= LEN_W'(WORD_BITS));
	assign free_ok  = (req.run_length <= LEN_W'(WORD_BITS))
		&& (({1'b0, req.start_offset} + (ENTRY_W + 1)'(req.run_length))
			<= {w_cfg, {POS_W{1'b0}}});
	assign req_span = (CNT_W'(req.start_offset[POS_W +: IDX_W]) + CNT_W'(1)) < w_cfg;

	bra_fit_search u_fit (
		.lo_word (a_q),
		.hi_word (b_word),
		.mask    (mask),
		.found   (fit_found),
		.pos     (fit_pos)
	);

	bra_bitmap_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.rdata  (rdata)
	);

	// next state, memory requests and result
	always_comb begin
		state_d  = state_q;
		mreq     = '0;
		res_d    = '0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					if (req.opcode == OP_ALLOC) begin
						if (alloc_ok) begin
							mreq.rd_en = 1'b1;
							state_d    = ST_SCAN;
						end else begin
							state_d = ST_FIN;
						end
					end else begin
						res_d.success = free_ok;
						if (free_ok && req.run_length != '0) begin
							mreq.rd_en   = 1'b1;
							mreq.rd_addr = req.start_offset[POS_W +: IDX_W];
							state_d      = ST_FRD0;
						end else begin
							state_d = ST_FIN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (idx_inc < w_q) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = idx_inc[IDX_W-1:0];
				end
				if (idx_q != '0 && fit_found) begin
					res_load             = 1'b1;
					res_d.success        = 1'b1;
					res_d.granted_offset = {idx_dec[IDX_W-1:0], fit_pos};
					state_d              = ST_WR0;
				end else if (idx_q == w_q) begin
					res_load = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_FRD0: begin
				if (span_q) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = i_inc[IDX_W-1:0];
					state_d      = ST_FRD1;
				end else begin
					state_d = ST_WR0;
				end
			end
			ST_FRD1: begin
				state_d = ST_WR0;
			end
			ST_WR0: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = i_q;
				mreq.wr_data = (op_q == OP_ALLOC) ? (a_q | run_bits[WORD_BITS-1:0])
					: (a_q & ~run_bits[WORD_BITS-1:0]);
				state_d      = span_q ? ST_WR1 : ST_FIN;
			end
			ST_WR1: begin
				mreq.wr_en   = 1'b1;
				mreq.wr_addr = i_inc[IDX_W-1:0];
				mreq.wr_data = (op_q == OP_ALLOC) ? (b_q | run_bits[2*WORD_BITS-1:WORD_BITS])
					: (b_q & ~run_bits[2*WORD_BITS-1:WORD_BITS]);
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if (fin_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (fin_load) begin
			out_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				op_q   <= req.opcode;
				n_q    <= req.run_length;
				w_q    <= w_cfg;
				i_q    <= req.start_offset[POS_W +: IDX_W];
				j_q    <= req.start_offset[POS_W-1:0];
				span_q <= req_span;
				idx_q  <= '0;
			end
			ST_SCAN: begin
				idx_q <= idx_inc;
				if (idx_q != '0 && fit_found) begin
					i_q    <= idx_dec[IDX_W-1:0];
					j_q    <= fit_pos;
					b_q    <= b_word;
					span_q <= (idx_q < w_q);
				end else begin
					a_q <= rdata;
				end
			end
			ST_FRD0: begin
				a_q <= rdata;
			end
			ST_FRD1: begin
				b_q <= rdata;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`include "bitmap_run_allocator_macros.svh"

	`BRA_ASSERT(a_wr_in_pool, mreq.wr_en, CNT_W'(mreq.wr_addr) < w_q, "write outside pool")
	`BRA_ASSERT_NEXT(a_busy_after_req, accept, state_q != ST_IDLE, "idle after transfer")
	`BRA_ASSERT(a_fail_zero_off, rsp_valid && !rsp.success, rsp.granted_offset == '0, "offset on fail")

endmodule

// ===== tb/sv/bitmap_run_allocator_test.sv =====
// Testbench of bitmap_run_allocator: directed and random allocate/free traffic, checked
// against an in-bench model of the occupancy bitmap, under several pool sizes.
// Depends on bra_pkg and the bitmap_run_allocator RTL.
module bitmap_run_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bra_pkg::*;

	typedef struct {
		int unsigned first;
		int unsigned len;
	} run_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	logic [WORD_BITS-1:0] occupancy [POOL_WORDS];
	logic [4:0]           pool_reg;
	rsp_t                 expected_rsp [$];
	run_t                 held_runs [$];
	int unsigned          mismatches;
	bit                   calm;

	bitmap_run_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("bitmap_run_allocator_test NOT OK");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic rsp_t predict_rsp(input req_t r);
		int unsigned w;
		int unsigned n;
		int unsigned first;
		int unsigned word_idx;
		int unsigned bit_pos;
		logic [WORD_BITS-1:0] mask;
		logic [WORD_BITS-1:0] lo;
		logic [WORD_BITS-1:0] hi;
		logic [WORD_BITS-1:0] window;
		bit found;
		rsp_t res;
		w = (pool_reg == 0) ? 1 : (pool_reg > POOL_WORDS) ? POOL_WORDS : pool_reg;
		n = r.run_length;
		first = r.start_offset;
		res = '0;
		found = 1'b0;
		mask = (n >= WORD_BITS) ? '1 : (WORD_BITS'(1) << n) - WORD_BITS'(1);
		if (r.opcode == OP_ALLOC) begin
			if (n >= 1 && n <= WORD_BITS) begin
				for (int i = 0; i < w && !found; i++) begin
					lo = occupancy[i];
					hi = (i + 1 < w) ? occupancy[i + 1] : '1;
					if (lo != '1) begin
						for (int j = 0; j < WORD_BITS && !found; j++) begin
							window = (j == 0) ? lo : ((lo >> j) | (hi << (WORD_BITS - j)));
							if ((window & mask) == '0) begin
								found = 1'b1;
								res.success = 1'b1;
								res.granted_offset = ENTRY_W'(i * WORD_BITS + j);
								occupancy[i] |= mask << j;
								if (j > 0 && i + 1 < w)
									occupancy[i + 1] |= mask >> (WORD_BITS - j);
							end
						end
					end
				end
			end
		end else if (n <= WORD_BITS && first + n <= w * WORD_BITS) begin
			res.success = 1'b1;
			word_idx = first / WORD_BITS;
			bit_pos = first % WORD_BITS;
			if (word_idx < w) begin
				occupancy[word_idx] &= ~(mask << bit_pos);
				if (bit_pos > 0 && word_idx + 1 < w)
					occupancy[word_idx + 1] &= ~(mask >> (WORD_BITS - bit_pos));
			end
		end
		return res;
	endfunction

	function automatic req_t make_req(input op_t op, input int unsigned n,
			input int unsigned first);
		req_t r;
		r.opcode = op;
		r.run_length = LEN_W'(n);
		r.start_offset = ENTRY_W'(first);
		return r;
	endfunction

	function automatic req_t next_random_req();
		int unsigned pick;
		int unsigned k;
		run_t run;
		pick = $urandom_range(0, 99);
		if (held_runs.size() > 24)
			pick = 50 + pick / 2;
		if (pick < 50 || (pick < 88 && held_runs.size() == 0))
			return make_req(OP_ALLOC, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) :
				$urandom_range(1, 8), $urandom_range(0, 511));
		if (pick < 88) begin
			k = $urandom_range(0, held_runs.size() - 1);
			run = held_runs[k];
			held_runs.delete(k);
			return make_req(OP_FREE, run.len, run.first);
		end
		return make_req(op_t'($urandom_range(0, 1)), $urandom_range(0, 63),
			$urandom_range(0, 511));
	endfunction

	task automatic send_req(input req_t r);
		rsp_t want;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		want = predict_rsp(r);
		expected_rsp.push_back(want);
		if (r.opcode == OP_ALLOC && want.success)
			held_runs.push_back('{want.granted_offset, r.run_length});
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [4:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_WORDS_IN_USE, 2'b00};
		pwdata <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr)
			pool_reg = value;
		else if (prdata !== DATA_W'(pool_reg))
			flag_mismatch($sformatf("words_in_use read %0h, want %0h", prdata, pool_reg));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_pool_words(input logic [4:0] value);
		drain();
		apb_access(1'b1, value);
		apb_access(1'b0, value);
	endtask

	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				flag_mismatch($sformatf("unexpected transfer %p", rsp));
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.success !== want.success)
					flag_mismatch($sformatf("success %b, want %b", rsp.success, want.success));
				if (rsp.granted_offset !== want.granted_offset)
					flag_mismatch($sformatf("granted_offset %0d, want %0d",
						rsp.granted_offset, want.granted_offset));
			end
		end
	end

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic test_reset_pool();
		send_req(make_req(OP_ALLOC, 0, 0));
		send_req(make_req(OP_ALLOC, 33, 0));
		send_req(make_req(OP_ALLOC, 63, 511));
		send_req(make_req(OP_ALLOC, 1, 511));
		send_req(make_req(OP_ALLOC, 32, 0));
		send_req(make_req(OP_ALLOC, 31, 0));
		send_req(make_req(OP_FREE, 0, 100));
		send_req(make_req(OP_FREE, 33, 0));
		send_req(make_req(OP_FREE, 1, 511));
		send_req(make_req(OP_FREE, 2, 511));
		send_req(make_req(OP_FREE, 5, 200));
		send_req(make_req(OP_FREE, 32, 1));
		send_req(make_req(OP_ALLOC, 32, 0));
	endtask

	task automatic test_pool_size();
		set_pool_words(5'd1);
		send_req(make_req(OP_FREE, 32, 0));
		send_req(make_req(OP_ALLOC, 32, 0));
		send_req(make_req(OP_ALLOC, 1, 0));
		send_req(make_req(OP_FREE, 17, 16));
		send_req(make_req(OP_FREE, 0, 32));
		set_pool_words(5'd0);
		send_req(make_req(OP_FREE, 32, 0));
		send_req(make_req(OP_ALLOC, 20, 0));
		send_req(make_req(OP_ALLOC, 12, 0));
		send_req(make_req(OP_ALLOC, 1, 0));
		set_pool_words(5'd31);
		send_req(make_req(OP_ALLOC, 1, 0));
	endtask

	task automatic test_random_traffic();
		logic [4:0] sizes [8];
		sizes = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'($urandom_range(1, 16)), 5'd17};
		foreach (sizes[p]) begin
			set_pool_words(sizes[p]);
			repeat (200) send_req(next_random_req());
		end
		set_pool_words(5'd16);
		calm = 1'b1;
		repeat (100) send_req(next_random_req());
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		calm = 1'b0;
		pool_reg = 5'(WORDS_RESET);
		foreach (occupancy[k])
			occupancy[k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_pool();
		test_pool_size();
		test_random_traffic();
		drain();
		if (mismatches == 0) begin
			$display("bitmap_run_allocator_test OK");
		end else begin
			$display("bitmap_run_allocator_test NOT OK");
		end
		$finish;
	end

endmodule
